// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks in the I2C register transfer block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/i2c_mrt_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master register transfer package
// Types, codes and constants shared by the I2C register transfer block.
// ----------------------------------------------------------------------------
package i2c_mrt_pkg;

    // Field widths of the request and result payloads.
    localparam int MODE_W     = 2;
    localparam int DEV_ADDR_W = 7;
    localparam int BYTE_W     = 8;
    localparam int TIMEOUT_W  = 10;
    localparam int QTR_W      = 2;
    localparam int BIT_CNT_W  = 4;

    // Configuration port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'b0;

    // Reset value of the acknowledge timeout.
    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 10'd250;

    // Request modes.
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK     = 2'd0,
        MODE_BEGIN_WR = 2'd1,
        MODE_BEGIN_RD = 2'd2,
        MODE_SUPPLY   = 2'd3
    } t_mode;

    // Bus phases, one-hot.
    typedef enum logic [8:0] {
        PH_IDLE   = 9'b000000001,
        PH_START  = 9'b000000010,
        PH_RSTART = 9'b000000100,
        PH_TX     = 9'b000001000,
        PH_ACK    = 9'b000010000,
        PH_WAITD  = 9'b000100000,
        PH_RX     = 9'b001000000,
        PH_MACK   = 9'b010000000,
        PH_STOP   = 9'b100000000
    } t_phase;

    // Kind of byte being transmitted.
    typedef enum logic [1:0] {
        KIND_ADDR   = 2'd0,
        KIND_REG    = 2'd1,
        KIND_ADDR_R = 2'd2,
        KIND_DATA   = 2'd3
    } t_kind;

    // Quarter-bit steps.
    localparam logic [QTR_W-1:0] QTR_0 = 2'd0;
    localparam logic [QTR_W-1:0] QTR_1 = 2'd1;
    localparam logic [QTR_W-1:0] QTR_2 = 2'd2;
    localparam logic [QTR_W-1:0] QTR_3 = 2'd3;

    // One result of the engine.
    typedef struct packed {
        logic              scl;
        logic              sda_pull_low;
        logic              busy_res;
        logic              data_request;
        logic [BYTE_W-1:0] read_data;
        logic              read_valid;
        logic              done_res;
        logic              error;
    } t_result;

endpackage

// ----- hw/rtl/i2c_mrt_if.sv -----
// ----------------------------------------------------------------------------
// I2C master register transfer channels
// Valid/ready request and result channels of the I2C register transfer block.
// ----------------------------------------------------------------------------

// Request channel: commands, ticks and sampled SDA.
interface i2c_mrt_in_if;
    logic                                valid;
    logic                                ready;
    logic [i2c_mrt_pkg::MODE_W-1:0]      mode;
    logic                                sda_in;
    logic [i2c_mrt_pkg::DEV_ADDR_W-1:0]  dev_addr;
    logic [i2c_mrt_pkg::BYTE_W-1:0]      reg_addr;
    logic [i2c_mrt_pkg::BYTE_W-1:0]      length;
    logic [i2c_mrt_pkg::BYTE_W-1:0]      write_data;

    modport source (
        output valid, mode, sda_in, dev_addr, reg_addr, length, write_data,
        input  ready
    );
    modport sink (
        input  valid, mode, sda_in, dev_addr, reg_addr, length, write_data,
        output ready
    );
endinterface

// Result channel: bus line levels and transaction status.
interface i2c_mrt_out_if;
    logic                           valid;
    logic                           ready;
    logic                           scl;
    logic                           sda_pull_low;
    logic                           busy_res;
    logic                           data_request;
    logic [i2c_mrt_pkg::BYTE_W-1:0] read_data;
    logic                           read_valid;
    logic                           done_res;
    logic                           error;

    modport source (
        output valid, scl, sda_pull_low, busy_res, data_request, read_data,
               read_valid, done_res, error,
        input  ready
    );
    modport sink (
        input  valid, scl, sda_pull_low, busy_res, data_request, read_data,
               read_valid, done_res, error,
        output ready
    );
endinterface

// ----- hw/rtl/i2c_mrt_cfg.sv -----
// ----------------------------------------------------------------------------
// I2C master register transfer configuration
// APB-style register file holding the acknowledge timeout.
// ----------------------------------------------------------------------------
module i2c_mrt_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_psel,
    input  logic                                 i_penable,
    input  logic                                 i_pwrite,
    input  logic [i2c_mrt_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  logic [i2c_mrt_pkg::APB_DATA_W-1:0]   i_pwdata,
    output logic [i2c_mrt_pkg::APB_DATA_W-1:0]   o_prdata,
    output logic                                 o_pready,
    output logic [i2c_mrt_pkg::TIMEOUT_W-1:0]    o_ack_timeout
);

    logic [i2c_mrt_pkg::REG_IDX_W-1:0] reg_idx;
    logic                              wr_en;
    logic [i2c_mrt_pkg::TIMEOUT_W-1:0] r_ack_timeout;

    // Word index decode and write strobe in the access cycle.
    assign reg_idx = i_paddr[i2c_mrt_pkg::APB_ADDR_W-1:2];
    assign wr_en   = i_psel & i_penable & i_pwrite;

    // Timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= i2c_mrt_pkg::ACK_TIMEOUT_RST;
        end else if (wr_en && reg_idx == i2c_mrt_pkg::REG_ACK_TIMEOUT) begin
            r_ack_timeout <= i_pwdata[i2c_mrt_pkg::TIMEOUT_W-1:0];
        end
    end

    // Read data; unmapped words read as zero.
    always_comb begin
        o_prdata = '0;
        if (reg_idx == i2c_mrt_pkg::REG_ACK_TIMEOUT) begin
            o_prdata = {{(i2c_mrt_pkg::APB_DATA_W - i2c_mrt_pkg::TIMEOUT_W){1'b0}},
                        r_ack_timeout};
        end
    end

    assign o_pready      = 1'b1;
    assign o_ack_timeout = r_ack_timeout;

endmodule

// ----- hw/rtl/i2c_mrt_engine.sv -----
// ----------------------------------------------------------------------------
// I2C master register transfer engine
// Bus state and the combinational next-state logic for one request.
// ----------------------------------------------------------------------------
module i2c_mrt_engine (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_step,
    input  logic [i2c_mrt_pkg::MODE_W-1:0]       i_mode,
    input  logic                                 i_sda_in,
    input  logic [i2c_mrt_pkg::DEV_ADDR_W-1:0]   i_dev_addr,
    input  logic [i2c_mrt_pkg::BYTE_W-1:0]       i_reg_addr,
    input  logic [i2c_mrt_pkg::BYTE_W-1:0]       i_length,
    input  logic [i2c_mrt_pkg::BYTE_W-1:0]       i_write_data,
    input  logic [i2c_mrt_pkg::TIMEOUT_W-1:0]    i_ack_timeout,
    output i2c_mrt_pkg::t_result                 o_result
);

    i2c_mrt_pkg::t_phase                  r_phase,    n_phase;
    i2c_mrt_pkg::t_kind                   r_kind,     n_kind;
    logic [i2c_mrt_pkg::QTR_W-1:0]        r_qtr,      n_qtr;
    logic [i2c_mrt_pkg::BIT_CNT_W-1:0]    r_bit_cnt,  n_bit_cnt;
    logic [i2c_mrt_pkg::BYTE_W-1:0]       r_shift,    n_shift;
    logic [i2c_mrt_pkg::BYTE_W-1:0]       r_bytes,    n_bytes;
    logic [i2c_mrt_pkg::DEV_ADDR_W-1:0]   r_slave,    n_slave;
    logic [i2c_mrt_pkg::BYTE_W-1:0]       r_reg_addr, n_reg_addr;
    logic                                 r_is_read,  n_is_read;
    logic [i2c_mrt_pkg::TIMEOUT_W-1:0]    r_wait,     n_wait;
    logic                                 r_err,      n_err;
    logic                                 r_scl,      n_scl;
    logic                                 r_sda_low,  n_sda_low;

    i2c_mrt_pkg::t_mode                   mode;
    logic [i2c_mrt_pkg::BYTE_W-1:0]       bytes_dec;
    logic [i2c_mrt_pkg::BIT_CNT_W-1:0]    bit_inc;
    logic [i2c_mrt_pkg::BYTE_W-1:0]       rx_shift;
    logic                                 rd_valid;
    logic [i2c_mrt_pkg::BYTE_W-1:0]       rd_data;
    logic                                 done;
    logic                                 err_out;

    assign mode      = i2c_mrt_pkg::t_mode'(i_mode);
    assign bytes_dec = r_bytes - 8'd1;
    assign bit_inc   = r_bit_cnt + 4'd1;
    assign rx_shift  = {r_shift[i2c_mrt_pkg::BYTE_W-2:0], i_sda_in};

    // Next state for the request at the input.
    always_comb begin
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_qtr      = r_qtr;
        n_bit_cnt  = r_bit_cnt;
        n_shift    = r_shift;
        n_bytes    = r_bytes;
        n_slave    = r_slave;
        n_reg_addr = r_reg_addr;
        n_is_read  = r_is_read;
        n_wait     = r_wait;
        n_err      = r_err;
        n_scl      = r_scl;
        n_sda_low  = r_sda_low;
        rd_valid   = 1'b0;
        rd_data    = '0;
        done       = 1'b0;
        err_out    = 1'b0;

        case (mode)
            i2c_mrt_pkg::MODE_BEGIN_WR, i2c_mrt_pkg::MODE_BEGIN_RD: begin
                // A begin is only taken while the bus is idle.
                if (r_phase == i2c_mrt_pkg::PH_IDLE) begin
                    n_slave    = i_dev_addr;
                    n_reg_addr = i_reg_addr;
                    n_bytes    = i_length;
                    n_is_read  = (mode == i2c_mrt_pkg::MODE_BEGIN_RD);
                    n_err      = 1'b0;
                    n_wait     = '0;
                    n_bit_cnt  = '0;
                    n_phase    = i2c_mrt_pkg::PH_START;
                    n_qtr      = i2c_mrt_pkg::QTR_0;
                end
            end
            i2c_mrt_pkg::MODE_SUPPLY: begin
                // A write byte is only taken while one is requested.
                if (r_phase == i2c_mrt_pkg::PH_WAITD) begin
                    n_shift   = i_write_data;
                    n_kind    = i2c_mrt_pkg::KIND_DATA;
                    n_bit_cnt = '0;
                    n_qtr     = i2c_mrt_pkg::QTR_0;
                    n_phase   = i2c_mrt_pkg::PH_TX;
                end
            end
            default: begin
                // One quarter-bit tick.
                case (r_phase)
                    i2c_mrt_pkg::PH_START, i2c_mrt_pkg::PH_RSTART: begin
                        case (r_qtr)
                            i2c_mrt_pkg::QTR_0: begin
                                n_scl = 1'b0; n_sda_low = 1'b0; n_qtr = i2c_mrt_pkg::QTR_1;
                            end
                            i2c_mrt_pkg::QTR_1: begin
                                n_scl = 1'b1; n_sda_low = 1'b0; n_qtr = i2c_mrt_pkg::QTR_2;
                            end
                            i2c_mrt_pkg::QTR_2: begin
                                n_scl = 1'b1; n_sda_low = 1'b1; n_qtr = i2c_mrt_pkg::QTR_3;
                            end
                            default: begin
                                // Start condition done; load the address byte.
                                n_scl     = 1'b0;
                                n_sda_low = 1'b1;
                                if (r_phase == i2c_mrt_pkg::PH_START) begin
                                    n_shift = {r_slave, 1'b0};
                                    n_kind  = i2c_mrt_pkg::KIND_ADDR;
                                end else begin
                                    n_shift = {r_slave, 1'b1};
                                    n_kind  = i2c_mrt_pkg::KIND_ADDR_R;
                                end
                                n_bit_cnt = '0;
                                n_qtr     = i2c_mrt_pkg::QTR_0;
                                n_phase   = i2c_mrt_pkg::PH_TX;
                            end
                        endcase
                    end
                    i2c_mrt_pkg::PH_TX: begin
                        // Drive the MSB in quarter 0, SCL high in quarters 2 and 3.
                        if (r_qtr == i2c_mrt_pkg::QTR_0) begin
                            n_sda_low = ~r_shift[i2c_mrt_pkg::BYTE_W-1];
                        end
                        n_scl = r_qtr[1];
                        if (r_qtr == i2c_mrt_pkg::QTR_3) begin
                            n_shift   = {r_shift[i2c_mrt_pkg::BYTE_W-2:0], 1'b0};
                            n_bit_cnt = bit_inc;
                            n_qtr     = i2c_mrt_pkg::QTR_0;
                            if (bit_inc[i2c_mrt_pkg::BIT_CNT_W-1]) begin
                                n_phase = i2c_mrt_pkg::PH_ACK;
                                n_wait  = '0;
                            end
                        end else begin
                            n_qtr = r_qtr + 2'd1;
                        end
                    end
                    i2c_mrt_pkg::PH_ACK: begin
                        case (r_qtr)
                            i2c_mrt_pkg::QTR_0: begin
                                n_scl = 1'b0; n_sda_low = 1'b0; n_qtr = i2c_mrt_pkg::QTR_1;
                            end
                            i2c_mrt_pkg::QTR_1: begin
                                n_scl = 1'b0; n_qtr = i2c_mrt_pkg::QTR_2;
                            end
                            i2c_mrt_pkg::QTR_2: begin
                                n_scl = 1'b1; n_qtr = i2c_mrt_pkg::QTR_3;
                            end
                            default: begin
                                // Hold SCL high until the slave pulls SDA low or the acknowledge timeout expires.
                                n_scl = 1'b1;
                                if (!i_sda_in) begin
                                    case (r_kind)
                                        i2c_mrt_pkg::KIND_ADDR: begin
                                            n_shift   = r_reg_addr;
                                            n_kind    = i2c_mrt_pkg::KIND_REG;
                                            n_bit_cnt = '0;
                                            n_qtr     = i2c_mrt_pkg::QTR_0;
                                            n_phase   = i2c_mrt_pkg::PH_TX;
                                        end
                                        i2c_mrt_pkg::KIND_REG: begin
                                            if (r_is_read) begin
                                                n_phase = i2c_mrt_pkg::PH_RSTART;
                                                n_qtr   = i2c_mrt_pkg::QTR_0;
                                            end else if (r_bytes == '0) begin
                                                n_phase = i2c_mrt_pkg::PH_STOP;
                                                n_qtr   = i2c_mrt_pkg::QTR_0;
                                            end else begin
                                                n_phase = i2c_mrt_pkg::PH_WAITD;
                                            end
                                        end
                                        i2c_mrt_pkg::KIND_ADDR_R: begin
                                            if (r_bytes == '0) begin
                                                n_phase = i2c_mrt_pkg::PH_STOP;
                                                n_qtr   = i2c_mrt_pkg::QTR_0;
                                            end else begin
                                                n_phase   = i2c_mrt_pkg::PH_RX;
                                                n_bit_cnt = '0;
                                                n_qtr     = i2c_mrt_pkg::QTR_0;
                                                n_shift   = '0;
                                            end
                                        end
                                        default: begin
                                            n_bytes = bytes_dec;
                                            if (bytes_dec == '0) begin
                                                n_phase = i2c_mrt_pkg::PH_STOP;
                                                n_qtr   = i2c_mrt_pkg::QTR_0;
                                            end else begin
                                                n_phase = i2c_mrt_pkg::PH_WAITD;
                                            end
                                        end
                                    endcase
                                end else if (r_wait >= i_ack_timeout) begin
                                    n_err   = 1'b1;
                                    n_phase = i2c_mrt_pkg::PH_STOP;
                                    n_qtr   = i2c_mrt_pkg::QTR_0;
                                end else begin
                                    n_wait = r_wait + 10'd1;
                                end
                            end
                        endcase
                    end
                    i2c_mrt_pkg::PH_WAITD: begin
                        n_scl     = 1'b0;
                        n_sda_low = 1'b0;
                    end
                    i2c_mrt_pkg::PH_RX: begin
                        // Release SDA and sample it in quarter 3.
                        if (r_qtr == i2c_mrt_pkg::QTR_0) begin
                            n_sda_low = 1'b0;
                        end
                        n_scl = r_qtr[1];
                        if (r_qtr == i2c_mrt_pkg::QTR_3) begin
                            n_shift   = rx_shift;
                            n_bit_cnt = bit_inc;
                            n_qtr     = i2c_mrt_pkg::QTR_0;
                            if (bit_inc[i2c_mrt_pkg::BIT_CNT_W-1]) begin
                                rd_valid = 1'b1;
                                rd_data  = rx_shift;
                                n_phase  = i2c_mrt_pkg::PH_MACK;
                            end
                        end else begin
                            n_qtr = r_qtr + 2'd1;
                        end
                    end
                    i2c_mrt_pkg::PH_MACK: begin
                        // ACK every byte but the last, which gets a NACK.
                        if (r_qtr == i2c_mrt_pkg::QTR_0) begin
                            n_sda_low = (r_bytes > 8'd1);
                        end
                        n_scl = r_qtr[1];
                        if (r_qtr == i2c_mrt_pkg::QTR_3) begin
                            n_bytes = bytes_dec;
                            n_qtr   = i2c_mrt_pkg::QTR_0;
                            if (bytes_dec == '0) begin
                                n_phase = i2c_mrt_pkg::PH_STOP;
                            end else begin
                                n_phase   = i2c_mrt_pkg::PH_RX;
                                n_bit_cnt = '0;
                                n_shift   = '0;
                            end
                        end else begin
                            n_qtr = r_qtr + 2'd1;
                        end
                    end
                    i2c_mrt_pkg::PH_STOP: begin
                        case (r_qtr)
                            i2c_mrt_pkg::QTR_0: begin
                                n_scl = 1'b0; n_sda_low = 1'b1;
                            end
                            i2c_mrt_pkg::QTR_1: begin
                                n_scl = 1'b1; n_sda_low = 1'b1;
                            end
                            default: begin
                                n_scl = 1'b1; n_sda_low = 1'b0;
                            end
                        endcase
                        if (r_qtr == i2c_mrt_pkg::QTR_3) begin
                            done    = 1'b1;
                            err_out = r_err;
                            n_err   = 1'b0;
                            n_phase = i2c_mrt_pkg::PH_IDLE;
                            n_qtr   = i2c_mrt_pkg::QTR_0;
                        end else begin
                            n_qtr = r_qtr + 2'd1;
                        end
                    end
                    default: begin
                        // Idle: both lines released.
                        n_phase   = i2c_mrt_pkg::PH_IDLE;
                        n_qtr     = i2c_mrt_pkg::QTR_0;
                        n_scl     = 1'b1;
                        n_sda_low = 1'b0;
                    end
                endcase
            end
        endcase
    end

    // Result for this request, taken from the next state.
    always_comb begin
        o_result.scl          = n_scl;
        o_result.sda_pull_low = n_sda_low;
        o_result.busy_res     = (n_phase != i2c_mrt_pkg::PH_IDLE);
        o_result.data_request = (n_phase == i2c_mrt_pkg::PH_WAITD);
        o_result.read_data    = rd_data;
        o_result.read_valid   = rd_valid;
        o_result.done_res     = done;
        o_result.error        = err_out;
    end

    // State registers advance once per accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= i2c_mrt_pkg::PH_IDLE;
            r_kind     <= i2c_mrt_pkg::KIND_ADDR;
            r_qtr      <= i2c_mrt_pkg::QTR_0;
            r_bit_cnt  <= '0;
            r_shift    <= '0;
            r_bytes    <= '0;
            r_slave    <= '0;
            r_reg_addr <= '0;
            r_is_read  <= 1'b0;
            r_wait     <= '0;
            r_err      <= 1'b0;
            r_scl      <= 1'b1;
            r_sda_low  <= 1'b0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_kind     <= n_kind;
            r_qtr      <= n_qtr;
            r_bit_cnt  <= n_bit_cnt;
            r_shift    <= n_shift;
            r_bytes    <= n_bytes;
            r_slave    <= n_slave;
            r_reg_addr <= n_reg_addr;
            r_is_read  <= n_is_read;
            r_wait     <= n_wait;
            r_err      <= n_err;
            r_scl      <= n_scl;
            r_sda_low  <= n_sda_low;
        end
    end

endmodule

// ----- hw/rtl/i2c_mrt_out_reg.sv -----
// ----------------------------------------------------------------------------
// I2C master register transfer result register
// Holds one result and decouples the result channel from the engine.
// ----------------------------------------------------------------------------
module i2c_mrt_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  i2c_mrt_pkg::t_result  i_result,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_can_load,
    output i2c_mrt_pkg::t_result  o_result
);

    logic                 r_valid;
    i2c_mrt_pkg::t_result r_result;

    // A new result may enter when the slot is empty or being drained.
    assign o_can_load = ~r_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload carries no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

// ----- hw/rtl/i2c_master_register_transfer.sv -----
// ----------------------------------------------------------------------------
// I2C master register transfer
// Open-drain I2C master that runs register write and read transactions.
// ----------------------------------------------------------------------------
// Every request (a tick, a begin command or a write byte) yields exactly one
// result, which appears in the cycle after the request is accepted. The engine
// computes the next bus state and the result combinationally, and a result
// register holds it, so a new request is accepted in every cycle unless the
// result register is full and its consumer stalls. Each tick is one quarter
// of an SCL bit; the acknowledge timeout, counted in ticks, is set through the
// APB port at word 0 (reset 250) and may only be changed while the bus is idle.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    i2c_mrt_in_if.sink                           i_in,
    i2c_mrt_out_if.source                        o_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [i2c_mrt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [i2c_mrt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [i2c_mrt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                 pready
);

    logic [i2c_mrt_pkg::TIMEOUT_W-1:0] ack_timeout;
    logic                              can_load;
    logic                              step;
    i2c_mrt_pkg::t_result              eng_result;
    i2c_mrt_pkg::t_result              out_result;

    // Configuration registers.
    i2c_mrt_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_prdata      (prdata),
        .o_pready      (pready),
        .o_ack_timeout (ack_timeout)
    );

    // Request handshake.
    assign i_in.ready = can_load;
    assign step       = i_in.valid & can_load;

    // Bus engine.
    i2c_mrt_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_mode        (i_in.mode),
        .i_sda_in      (i_in.sda_in),
        .i_dev_addr    (i_in.dev_addr),
        .i_reg_addr    (i_in.reg_addr),
        .i_length      (i_in.length),
        .i_write_data  (i_in.write_data),
        .i_ack_timeout (ack_timeout),
        .o_result      (eng_result)
    );

    // Result register.
    i2c_mrt_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step),
        .i_result    (eng_result),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_can_load  (can_load),
        .o_result    (out_result)
    );

    assign o_out.scl          = out_result.scl;
    assign o_out.sda_pull_low = out_result.sda_pull_low;
    assign o_out.busy_res     = out_result.busy_res;
    assign o_out.data_request = out_result.data_request;
    assign o_out.read_data    = out_result.read_data;
    assign o_out.read_valid   = out_result.read_valid;
    assign o_out.done_res     = out_result.done_res;
    assign o_out.error        = out_result.error;

endmodule

// ----- hw/rtl/i2c_mrt_checker.sv -----
// ----------------------------------------------------------------------------
// I2C master register transfer checker
// Port-level checks on the result channel of the I2C register transfer block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_mrt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_scl,
    input logic                           i_sda_pull_low,
    input logic                           i_busy_res,
    input logic                           i_data_request,
    input logic [i2c_mrt_pkg::BYTE_W-1:0] i_read_data,
    input logic                           i_read_valid,
    input logic                           i_done_res,
    input logic                           i_error
);

    logic                           out_stall;
    logic                           dreq_seen;
    logic [i2c_mrt_pkg::BYTE_W+6:0] out_word;

    // Result channel shorthands.
    assign out_stall = i_out_valid & ~i_out_ready;
    assign dreq_seen = i_out_valid & i_data_request;
    assign out_word  = {i_scl, i_sda_pull_low, i_busy_res, i_data_request,
                        i_read_data, i_read_valid, i_done_res, i_error};

    // A finished transaction leaves the bus idle.
    `ASSERT_SAME(a_done_not_busy, i_clk, i_rst_n, i_out_valid && i_done_res, !i_busy_res)

    // An error is only reported with the end of a transaction.
    `ASSERT_SAME(a_error_with_done, i_clk, i_rst_n, i_out_valid && i_error, i_done_res)

    // While a write byte is requested, the bus is busy and SDA is released.
    // SCL is still high on the first such result, right after the acknowledge.
    `ASSERT_SAME(a_wait_lines, i_clk, i_rst_n, dreq_seen, i_busy_res && !i_sda_pull_low)

    // A stalled result stays in place.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_word))

endmodule

bind i2c_master_register_transfer i2c_mrt_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_scl          (o_out.scl),
    .i_sda_pull_low (o_out.sda_pull_low),
    .i_busy_res     (o_out.busy_res),
    .i_data_request (o_out.data_request),
    .i_read_data    (o_out.read_data),
    .i_read_valid   (o_out.read_valid),
    .i_done_res     (o_out.done_res),
    .i_error        (o_out.error)
);
